[hw/rtl/ske_pkg.sv]
`timescale 1ns / 1ps

package ske_pkg;

    localparam int MAX_KMER     = 8;
    localparam int BITMAP_DEPTH = 1048576;
    localparam int TABLE_DEPTH  = 256;

    localparam int CODE_W  = 40;
    localparam int SYM_W   = 5;
    localparam int CHAR_W  = 8;
    localparam int POS_W   = 16;
    localparam int KLEN_W  = 4;
    localparam int RADIX_W = 6;
    localparam int CNT_W   = $clog2(MAX_KMER + 1);
    localparam int TBL_AW  = $clog2(TABLE_DEPTH);

    localparam int ROW_W   = 64;
    localparam int ROW_BW  = $clog2(ROW_W);
    localparam int BM_AW   = $clog2(BITMAP_DEPTH);
    localparam int ROW_AW  = BM_AW - ROW_BW;
    localparam int BM_ROWS = (BITMAP_DEPTH + ROW_W - 1) / ROW_W;

    localparam logic [CODE_W:0] BM_LIMIT = (CODE_W + 1)'(BITMAP_DEPTH);
    localparam logic [CHAR_W-1:0] CASE_MASK = 8'hDF;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_KMER_LEN = 2'd0;
    localparam logic [1:0] REG_STRIDE   = 2'd1;
    localparam logic [1:0] REG_ALPHABET = 2'd2;

    localparam logic [KLEN_W-1:0]  KLEN_RST  = 4'd6;
    localparam logic [POS_W-1:0]   STRIDE_RST = 16'd1;
    localparam logic [RADIX_W-1:0] ALPHA_RST = 6'd25;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_CHAR = 1'b1;

    typedef struct packed {
        logic             foreign;
        logic [SYM_W-1:0] code;
    } t_tab_entry;

    typedef struct packed {
        logic              rd_en;
        logic              set_en;
        logic [ROW_AW-1:0] row;
        logic [ROW_BW-1:0] bsel;
    } t_bm_ctl;

    typedef struct packed {
        logic busy;
        logic was_set;
    } t_bm_stat;

endpackage

[hw/rtl/ske_cell.sv]
`timescale 1ns / 1ps

module ske_cell
    import ske_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_shift,
    input  logic               i_active,
    input  logic [RADIX_W-1:0] i_radix,
    input  logic [SYM_W-1:0]   i_sym,
    output logic [SYM_W-1:0]   o_sym,
    input  logic [CODE_W-1:0]  i_acc,
    output logic [CODE_W-1:0]  o_acc
);

    logic [SYM_W-1:0]  r_sym;
    logic [CODE_W-1:0] r_acc;
    logic [CODE_W-1:0] n_acc;

    always_comb begin
        n_acc = CODE_W'(i_acc * i_radix) + CODE_W'(i_active ? r_sym : '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sym <= i_sym;
        end
        r_acc <= n_acc;
    end

    assign o_sym = r_sym;
    assign o_acc = r_acc;

endmodule

[hw/rtl/ske_chain.sv]
`timescale 1ns / 1ps

module ske_chain
    import ske_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_shift,
    input  logic               i_clear,
    input  logic [SYM_W-1:0]   i_sym,
    input  logic [CNT_W-1:0]   i_k,
    input  logic [RADIX_W-1:0] i_radix,
    output logic [CODE_W-1:0]  o_acc
);

    logic [SYM_W-1:0]  w_sym [MAX_KMER];
    logic [SYM_W-1:0]  w_sin [MAX_KMER];
    logic [CODE_W-1:0] w_acc [MAX_KMER+1];

    assign w_acc[MAX_KMER] = '0;

    for (genvar j = 0; j < MAX_KMER; j++) begin : g_cell
        if (j == 0) begin : g_head
            assign w_sin[j] = i_sym;
        end else begin : g_body
            assign w_sin[j] = i_clear ? '0 : w_sym[j-1];
        end

        ske_cell u_cell (
            .i_clk    (i_clk),
            .i_shift  (i_shift),
            .i_active (CNT_W'(j) < i_k),
            .i_radix  (i_radix),
            .i_sym    (w_sin[j]),
            .o_sym    (w_sym[j]),
            .i_acc    (w_acc[j+1]),
            .o_acc    (w_acc[j])
        );
    end

    assign o_acc = w_acc[0];

endmodule

[hw/rtl/ske_bitmap.sv]
`timescale 1ns / 1ps

module ske_bitmap
    import ske_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_bm_ctl  i_ctl,
    output t_bm_stat o_stat
);

    logic [ROW_W-1:0]  r_mem [BM_ROWS];
    logic [ROW_W-1:0]  r_rd_data;
    logic              r_busy;
    logic [ROW_AW-1:0] r_clr_row;
    logic [ROW_W-1:0]  w_bit;

    assign w_bit = ROW_W'(1) << i_ctl.bsel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_row <= '0;
        end else if (r_busy) begin
            if (r_clr_row == ROW_AW'(BM_ROWS - 1)) begin
                r_busy <= 1'b0;
            end
            r_clr_row <= r_clr_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_row] <= '0;
        end else if (i_ctl.set_en) begin
            r_mem[i_ctl.row] <= r_rd_data | w_bit;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_ctl.row];
        end
    end

    assign o_stat.busy    = r_busy;
    assign o_stat.was_set = r_rd_data[i_ctl.bsel];

endmodule

[hw/rtl/strided_kmer_encoder_top.sv]
`timescale 1ns / 1ps
// Channel  Direction  Handshake                   Payload
// in       input      i_in_valid / o_in_stall     command, char_byte, seq_start, map_code,
//                                                 map_foreign
// out      output     o_out_valid / i_out_stall   kmer_valid, kmer_code, kmer_offset,
//                                                 kmer_eliminated, first_seen, code_overflow
// cfg      input      APB psel/penable/pwrite     kmer_length, stride, alphabet_size
//
// A load transaction visits IDLE and EMIT, a character that completes no emitted window
// IDLE, LOOK and EMIT, and an emitted window IDLE, LOOK, CALC and EMIT: the code settles
// through the chain of MAX_KMER multiply-add cells, then one presence bitmap row is read
// and written back unless the code overflows. After reset the bitmap is cleared one 64-bit
// row per cycle, all BM_ROWS (16384) rows, and no transaction is accepted until that pass
// ends. A new transaction is accepted while a result waits in the output register under stall.

module strided_kmer_encoder_top
    import ske_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_command,
    input  logic [CHAR_W-1:0] i_char_byte,
    input  logic              i_seq_start,
    input  logic [SYM_W-1:0]  i_map_code,
    input  logic              i_map_foreign,

    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_kmer_valid,
    output logic [CODE_W-1:0] o_kmer_code,
    output logic [POS_W-1:0]  o_kmer_offset,
    output logic              o_kmer_eliminated,
    output logic              o_first_seen,
    output logic              o_code_overflow,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_CALC,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic              kmer_valid;
        logic [CODE_W-1:0] code;
        logic [POS_W-1:0]  offset;
        logic              eliminated;
        logic              overflow;
    } t_result;

    t_state r_state;

    logic [KLEN_W-1:0]  r_klen;
    logic [POS_W-1:0]   r_stride;
    logic [RADIX_W-1:0] r_alpha;

    logic [CNT_W-1:0]   r_clean;
    logic [CNT_W-1:0]   r_fill;
    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   r_phase;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_start;
    logic               r_mark;
    t_result            r_res;

    t_tab_entry         r_tab_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_tab_v;
    t_tab_entry         r_tab_q;
    logic               r_tab_hit;

    logic               r_out_valid;
    logic               r_out_kvalid;
    logic [CODE_W-1:0]  r_out_code;
    logic [POS_W-1:0]   r_out_offset;
    logic               r_out_elim;
    logic               r_out_first;
    logic               r_out_ovf;

    logic [CNT_W-1:0]   n_clean;
    logic [CNT_W-1:0]   n_fill;
    logic [POS_W-1:0]   n_pos;
    logic [POS_W-1:0]   n_phase;

    logic               w_in_acc;
    logic               w_out_free;
    logic               w_cfg_wr;
    logic [CHAR_W-1:0]  w_fold;
    logic               w_ld_ok;
    logic               w_rd_ok;
    logic [CNT_W-1:0]   w_k;
    logic [POS_W-1:0]   w_st;
    logic [CNT_W-1:0]   w_rem;
    logic               w_foreign;
    logic [SYM_W-1:0]   w_sym;
    logic [CNT_W-1:0]   w_clean0;
    logic [CNT_W-1:0]   w_fill0;
    logic [POS_W-1:0]   w_pos0;
    logic [POS_W-1:0]   w_phase;
    logic [POS_W:0]     w_phase_inc;
    logic               w_hit;
    logic [POS_W-1:0]   w_off;
    logic [CODE_W-1:0]  w_acc;
    logic               w_ovf;
    logic               w_calc_done;
    t_bm_ctl            w_bm_ctl;
    t_bm_stat           w_bm_stat;

    assign pready     = 1'b1;
    assign o_in_stall = (r_state != S_IDLE) || w_bm_stat.busy;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_cfg_wr   = psel && penable && pwrite && pready;

    assign w_fold  = i_char_byte & CASE_MASK;
    assign w_ld_ok = {1'b0, i_char_byte} < (CHAR_W + 1)'(TABLE_DEPTH);
    assign w_rd_ok = {1'b0, w_fold} < (CHAR_W + 1)'(TABLE_DEPTH);

    always_comb begin
        case (paddr[3:2])
            REG_KMER_LEN: prdata = APB_DW'(r_klen);
            REG_STRIDE:   prdata = APB_DW'(r_stride);
            REG_ALPHABET: prdata = APB_DW'(r_alpha);
            default:      prdata = '0;
        endcase
    end

    always_comb begin
        if (r_klen == '0) begin
            w_k = CNT_W'(1);
        end else if (r_klen > KLEN_W'(MAX_KMER)) begin
            w_k = CNT_W'(MAX_KMER);
        end else begin
            w_k = CNT_W'(r_klen);
        end
        w_st = (r_stride == '0) ? POS_W'(1) : r_stride;
    end

    always_comb begin
        w_rem = w_k - 1'b1;
        for (int i = 0; i < MAX_KMER - 1; i++) begin
            if (POS_W'(w_rem) >= w_st) begin
                w_rem = w_rem - w_st[CNT_W-1:0];
            end
        end
    end

    always_comb begin
        w_foreign   = !r_tab_hit || r_tab_q.foreign;
        w_sym       = r_tab_hit ? r_tab_q.code : '0;
        w_clean0    = r_start ? '0 : r_clean;
        w_fill0     = r_start ? '0 : r_fill;
        w_pos0      = r_start ? '0 : r_pos;
        w_phase     = r_start ? '0 : ((r_phase >= w_st) ? '0 : r_phase);
        w_phase_inc = {1'b0, w_phase} + 1'b1;

        if (w_foreign) begin
            n_clean = '0;
        end else if (w_clean0 < CNT_W'(MAX_KMER)) begin
            n_clean = w_clean0 + 1'b1;
        end else begin
            n_clean = w_clean0;
        end
        n_fill  = (w_fill0 < CNT_W'(MAX_KMER)) ? w_fill0 + 1'b1 : w_fill0;
        n_pos   = w_pos0 + 1'b1;
        n_phase = (w_phase_inc >= {1'b0, w_st}) ? '0 : w_phase_inc[POS_W-1:0];

        w_hit = (n_fill >= w_k) && (w_phase == POS_W'(w_rem));
        w_off = w_pos0 - POS_W'(w_k) + POS_W'(1);
    end

    ske_chain u_chain (
        .i_clk   (i_clk),
        .i_shift (r_state == S_LOOK),
        .i_clear (r_start),
        .i_sym   (w_sym),
        .i_k     (w_k),
        .i_radix (r_alpha),
        .o_acc   (w_acc)
    );

    assign w_ovf       = {1'b0, w_acc} >= BM_LIMIT;
    assign w_calc_done = (r_state == S_CALC) && (r_cnt == CNT_W'(MAX_KMER));

    always_comb begin
        w_bm_ctl.rd_en  = w_calc_done && !w_ovf;
        w_bm_ctl.set_en = (r_state == S_EMIT) && w_out_free && r_mark;
        if (r_state == S_CALC) begin
            w_bm_ctl.row  = w_acc[BM_AW-1:ROW_BW];
            w_bm_ctl.bsel = w_acc[ROW_BW-1:0];
        end else begin
            w_bm_ctl.row  = r_res.code[BM_AW-1:ROW_BW];
            w_bm_ctl.bsel = r_res.code[ROW_BW-1:0];
        end
    end

    ske_bitmap u_bitmap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_bm_ctl),
        .o_stat  (w_bm_stat)
    );

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_command == CMD_LOAD) && w_ld_ok) begin
            r_tab_mem[i_char_byte[TBL_AW-1:0]] <= '{foreign: i_map_foreign, code: i_map_code};
        end
        if (w_in_acc && (i_command == CMD_CHAR)) begin
            r_tab_q <= r_tab_mem[w_fold[TBL_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_v <= '0;
        end else begin
            if (w_in_acc && (i_command == CMD_LOAD) && w_ld_ok) begin
                r_tab_v[i_char_byte[TBL_AW-1:0]] <= 1'b1;
            end
            if (w_in_acc && (i_command == CMD_CHAR)) begin
                r_tab_hit <= w_rd_ok && r_tab_v[w_fold[TBL_AW-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_klen      <= KLEN_RST;
            r_stride    <= STRIDE_RST;
            r_alpha     <= ALPHA_RST;
            r_clean     <= '0;
            r_fill      <= '0;
            r_pos       <= '0;
            r_phase     <= '0;
            r_cnt       <= '0;
            r_mark      <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                case (paddr[3:2])
                    REG_KMER_LEN: r_klen   <= pwdata[KLEN_W-1:0];
                    REG_STRIDE:   r_stride <= pwdata[POS_W-1:0];
                    REG_ALPHABET: r_alpha  <= pwdata[RADIX_W-1:0];
                    default:      ;
                endcase
            end

            if (r_out_valid && !i_out_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_start <= i_seq_start;
                        r_mark  <= 1'b0;
                        if (i_command == CMD_LOAD) begin
                            r_res   <= '0;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_LOOK;
                        end
                    end
                end
                S_LOOK: begin
                    r_clean <= n_clean;
                    r_fill  <= n_fill;
                    r_pos   <= n_pos;
                    r_phase <= n_phase;
                    r_res.kmer_valid <= 1'b0;
                    r_res.code       <= '0;
                    r_res.overflow   <= 1'b0;
                    r_res.offset     <= w_hit ? w_off : '0;
                    if (w_hit && (n_clean >= w_k)) begin
                        r_res.eliminated <= 1'b0;
                        r_cnt            <= '0;
                        r_state          <= S_CALC;
                    end else begin
                        r_res.eliminated <= w_hit;
                        r_state          <= S_EMIT;
                    end
                end
                S_CALC: begin
                    if (w_calc_done) begin
                        r_res.kmer_valid <= 1'b1;
                        r_res.code       <= w_acc;
                        r_res.overflow   <= w_ovf;
                        r_mark           <= !w_ovf;
                        r_state          <= S_EMIT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_kvalid <= r_res.kmer_valid;
                        r_out_code   <= r_res.code;
                        r_out_offset <= r_res.offset;
                        r_out_elim   <= r_res.eliminated;
                        r_out_ovf    <= r_res.overflow;
                        r_out_first  <= r_mark && !w_bm_stat.was_set;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_kmer_valid      = r_out_kvalid;
    assign o_kmer_code       = r_out_code;
    assign o_kmer_offset     = r_out_offset;
    assign o_kmer_eliminated = r_out_elim;
    assign o_first_seen      = r_out_first;
    assign o_code_overflow   = r_out_ovf;

endmodule

[hw/rtl/ske_checker.sv]
`timescale 1ns / 1ps

module ske_checker
    import ske_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic              o_kmer_valid,
    input logic [CODE_W-1:0] o_kmer_code,
    input logic [POS_W-1:0]  o_kmer_offset,
    input logic              o_kmer_eliminated,
    input logic              o_first_seen,
    input logic              o_code_overflow
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_kmer_code) && $stable(o_kmer_offset))
        else $error("output transaction changed under stall");

    a_valid_elim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_kmer_valid && o_kmer_eliminated))
        else $error("window both emitted and eliminated");

    a_no_kmer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_kmer_valid |->
            (o_kmer_code == '0) && !o_first_seen && !o_code_overflow)
        else $error("code flags set without an emitted window");

    a_seen_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kmer_valid |-> !(o_first_seen && o_code_overflow))
        else $error("overflowed code reported as first seen");

endmodule

bind strided_kmer_encoder_top ske_checker u_ske_checker (.*);

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
    import ske_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int SETTLE_CYCLES  = MAX_KMER + 8;
    localparam int WATCHDOG_LIMIT = 4 * BM_ROWS;
    localparam int HOLD_AFTER     = 120;
    localparam int HOLD_CYCLES    = 400;
    localparam int N_PHASES       = 11;

    typedef struct packed {
        logic              cmd;
        logic [CHAR_W-1:0] ch;
        logic              start;
        logic [SYM_W-1:0]  map_code;
        logic              map_foreign;
    } t_seq_item;

    typedef struct packed {
        logic              hit;
        logic [CODE_W-1:0] code;
        logic [POS_W-1:0]  offset;
        logic              eliminated;
        logic              first_seen;
        logic              overflow;
    } t_kmer_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_command = 1'b0;
    logic [CHAR_W-1:0] i_char_byte = '0;
    logic              i_seq_start = 1'b0;
    logic [SYM_W-1:0]  i_map_code = '0;
    logic              i_map_foreign = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_kmer_valid;
    logic [CODE_W-1:0] o_kmer_code;
    logic [POS_W-1:0]  o_kmer_offset;
    logic              o_kmer_eliminated;
    logic              o_first_seen;
    logic              o_code_overflow;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    strided_kmer_encoder_top dut (.*);

    int unsigned ph_klen   [N_PHASES] = '{1, 2, 3, 8, 4, 0, 15, 5, 2, 8, 3};
    int unsigned ph_stride [N_PHASES] = '{1, 1, 2, 1, 3, 1, 5, 0, 65535, 7, 1};
    int unsigned ph_alpha  [N_PHASES] = '{2, 32, 4, 32, 25, 63, 63, 10, 3, 0, 5};
    int unsigned ph_items  [N_PHASES] = '{90, 60, 60, 60, 60, 60, 60, 60, 60, 60, 60};

    t_seq_item    pending_items[$];
    t_kmer_result expected_kmers[$];
    t_seq_item    on_bus;
    t_kmer_result want_kmer;

    logic [KLEN_W-1:0]  klen_cfg   = KLEN_RST;
    logic [POS_W-1:0]   stride_cfg = STRIDE_RST;
    logic [RADIX_W-1:0] alpha_cfg  = ALPHA_RST;

    t_tab_entry        char_tab [TABLE_DEPTH];
    logic [SYM_W-1:0]  sym_window [MAX_KMER] = '{default: '0};
    int unsigned       clean_run = 0;
    int unsigned       fill_count = 0;
    int unsigned       char_pos = 0;
    int unsigned       stride_ph = 0;
    bit                seen_map [BITMAP_DEPTH];

    int   n_fail = 0;
    int   gap_left = 0;
    int   burst_left = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;
    int   rx_count = 0;
    logic [31:0] rx_cycle = '0;
    int   idle_cycles = 0;

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic t_kmer_result encode_item(t_seq_item it);
        t_kmer_result      r;
        int unsigned       k;
        int unsigned       st;
        int unsigned       pos;
        int unsigned       phase;
        int                j;
        t_tab_entry        ent;
        logic [CODE_W-1:0] acc;
        r = '0;
        k = (klen_cfg == 0) ? 1 : ((klen_cfg > MAX_KMER) ? MAX_KMER : klen_cfg);
        st = (stride_cfg == 0) ? 1 : stride_cfg;
        if (it.cmd == CMD_LOAD) begin
            char_tab[it.ch] = '{foreign: it.map_foreign, code: it.map_code};
            return r;
        end
        if (it.start) begin
            for (j = 0; j < MAX_KMER; j++) sym_window[j] = '0;
            clean_run = 0;
            fill_count = 0;
            char_pos = 0;
            stride_ph = 0;
        end
        ent = char_tab[it.ch & CASE_MASK];
        for (j = MAX_KMER - 1; j > 0; j--) sym_window[j] = sym_window[j-1];
        sym_window[0] = ent.code;
        if (ent.foreign) begin
            clean_run = 0;
        end else if (clean_run < MAX_KMER) begin
            clean_run++;
        end
        if (fill_count < MAX_KMER) fill_count++;
        pos = char_pos;
        phase = (stride_ph >= st) ? 0 : stride_ph;
        char_pos = (pos + 1) & 32'hFFFF;
        stride_ph = (phase + 1 >= st) ? 0 : phase + 1;
        if (fill_count >= k && phase == (k - 1) % st) begin
            r.offset = POS_W'(pos - (k - 1));
            if (clean_run >= k) begin
                acc = '0;
                for (j = int'(k) - 1; j >= 0; j--) acc = acc * alpha_cfg + sym_window[j];
                r.hit = 1'b1;
                r.code = acc;
                if (acc >= BITMAP_DEPTH) begin
                    r.overflow = 1'b1;
                end else begin
                    r.first_seen = !seen_map[acc[BM_AW-1:0]];
                    seen_map[acc[BM_AW-1:0]] = 1'b1;
                end
            end else begin
                r.eliminated = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [CODE_W-1:0] want,
                                        logic [CODE_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            n_fail++;
        end
    endfunction

    task automatic push_item(logic cmd, logic [CHAR_W-1:0] ch, logic start,
                             logic [SYM_W-1:0] map_code, logic map_foreign);
        t_seq_item it;
        it = '{cmd, ch, start, map_code, map_foreign};
        pending_items = {pending_items, it};
    endtask

    function automatic logic [CHAR_W-1:0] letter_char();
        logic [CHAR_W-1:0] c;
        c = CHAR_W'(8'h41 + $urandom_range(0, 25));
        if ($urandom_range(0, 1) == 1) c = c | 8'h20;
        return c;
    endfunction

    task automatic gen_random_items(int count);
        t_seq_item it;
        for (int n = 0; n < count; n++) begin
            it.map_code = SYM_W'($urandom);
            it.map_foreign = ($urandom_range(0, 7) == 0);
            it.start = ($urandom_range(0, 24) == 0);
            if ($urandom_range(0, 99) < 8) begin
                it.cmd = CMD_LOAD;
                it.ch = ($urandom_range(0, 1) == 1) ? CHAR_W'(8'h41 + $urandom_range(0, 25))
                                                    : CHAR_W'($urandom);
            end else begin
                it.cmd = CMD_CHAR;
                it.ch = ($urandom_range(0, 9) < 8) ? letter_char() : CHAR_W'($urandom);
            end
            pending_items = {pending_items, it};
        end
    endtask

    task automatic set_register(logic [1:0] idx, logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] stored;
        case (idx)
            REG_KMER_LEN: stored = value & 32'hF;
            REG_STRIDE:   stored = value & 32'hFFFF;
            default:      stored = value & 32'h3F;
        endcase
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'({idx, 2'b00});
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_KMER_LEN: klen_cfg = stored[KLEN_W-1:0];
            REG_STRIDE:   stride_cfg = stored[POS_W-1:0];
            default:      alpha_cfg = stored[RADIX_W-1:0];
        endcase
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== stored) begin
            $error("register %0d: expected %0h, actual %0h", idx, stored, prdata);
            n_fail++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_drained();
        do begin
            while (pending_items.size() != 0 || i_in_valid || expected_kmers.size() != 0)
                @(posedge i_clk);
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end while (pending_items.size() != 0 || i_in_valid || expected_kmers.size() != 0);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left <= 0;
            burst_left <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) expected_kmers = {expected_kmers, encode_item(on_bus)};
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    i_in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pending_items.size() != 0) begin
                    on_bus = pending_items.pop_front();
                    i_in_valid <= 1'b1;
                    i_command <= on_bus.cmd;
                    i_char_byte <= on_bus.ch;
                    i_seq_start <= on_bus.start;
                    i_map_code <= on_bus.map_code;
                    i_map_foreign <= on_bus.map_foreign;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // The receiver stalls in a pattern set by rx_cycle[9:8], and once holds off
    // long enough for the block to fill up and stall its input.
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (o_out_valid && !i_out_stall) rx_count <= rx_count + 1;
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && rx_count >= HOLD_AFTER) begin
            i_out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            case (rx_cycle[9:8])
                2'd0: i_out_stall <= 1'b0;
                2'd1: i_out_stall <= ($urandom_range(0, 1) == 1);
                2'd2: i_out_stall <= (rx_cycle % 5 < 2);
                default: i_out_stall <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_kmers.size() == 0) begin
                $error("kmer result with no transaction pending");
                n_fail++;
            end else begin
                want_kmer = expected_kmers.pop_front();
                check_field("kmer_valid", want_kmer.hit, o_kmer_valid);
                check_field("kmer_code", want_kmer.code, o_kmer_code);
                check_field("kmer_offset", want_kmer.offset, o_kmer_offset);
                check_field("kmer_eliminated", want_kmer.eliminated, o_kmer_eliminated);
                check_field("first_seen", want_kmer.first_seen, o_first_seen);
                check_field("code_overflow", want_kmer.overflow, o_code_overflow);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) char_tab[i] = '{foreign: 1'b1, code: '0};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: table loads at both index extremes, case folding,
        // foreign characters, a sequence restart and a repeated window.
        push_item(CMD_LOAD, 8'h41, 1'b0, 5'd0, 1'b0);
        push_item(CMD_LOAD, 8'h42, 1'b0, 5'd31, 1'b0);
        push_item(CMD_LOAD, 8'h43, 1'b1, 5'd24, 1'b0);
        push_item(CMD_LOAD, 8'hFF, 1'b0, 5'd31, 1'b0);
        push_item(CMD_LOAD, 8'h00, 1'b0, 5'd0, 1'b1);
        push_item(CMD_LOAD, 8'h44, 1'b0, 5'd1, 1'b1);
        push_item(CMD_CHAR, 8'h61, 1'b1, 5'd0, 1'b0);
        push_item(CMD_CHAR, 8'h42, 1'b0, 5'd0, 1'b0);
        push_item(CMD_CHAR, 8'h63, 1'b0, 5'd0, 1'b0);
        push_item(CMD_CHAR, 8'h41, 1'b0, 5'd0, 1'b0);
        push_item(CMD_CHAR, 8'h62, 1'b0, 5'd0, 1'b0);
        push_item(CMD_CHAR, 8'h43, 1'b0, 5'd0, 1'b0);
        push_item(CMD_CHAR, 8'h61, 1'b0, 5'd0, 1'b0);
        push_item(CMD_CHAR, 8'h44, 1'b0, 5'd0, 1'b0);
        push_item(CMD_CHAR, 8'hFF, 1'b0, 5'd0, 1'b0);
        push_item(CMD_CHAR, 8'h20, 1'b0, 5'd0, 1'b0);
        push_item(CMD_CHAR, 8'h41, 1'b1, 5'd0, 1'b0);
        push_item(CMD_CHAR, 8'h42, 1'b0, 5'd0, 1'b0);
        push_item(CMD_CHAR, 8'h43, 1'b0, 5'd0, 1'b0);
        push_item(CMD_CHAR, 8'h61, 1'b0, 5'd0, 1'b0);
        push_item(CMD_CHAR, 8'h62, 1'b0, 5'd0, 1'b0);
        push_item(CMD_CHAR, 8'h63, 1'b0, 5'd0, 1'b0);
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            set_register(REG_KMER_LEN, ph_klen[p]);
            set_register(REG_STRIDE, ph_stride[p]);
            set_register(REG_ALPHABET, ph_alpha[p]);
            if (p == 0) begin
                for (int c = 0; c < 26; c++)
                    push_item(CMD_LOAD, CHAR_W'(8'h41 + c), 1'b0, SYM_W'($urandom),
                              $urandom_range(0, 7) == 0);
                gen_random_items(ph_items[p] - 26);
            end else begin
                gen_random_items(ph_items[p]);
            end
            wait_drained();
        end

        if (n_fail == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/ske_pkg.sv
hw/rtl/ske_cell.sv
hw/rtl/ske_chain.sv
hw/rtl/ske_bitmap.sv
hw/rtl/strided_kmer_encoder_top.sv
hw/rtl/ske_checker.sv
bench/tb.sv
